/* src/tdcs_pkg.sv */
// Shared types and constants for the TFT draw command stream generator.
`timescale 1ns / 1ps
`default_nettype none

package tdcs_pkg;

	// Default panel geometry and command queue depth
	localparam int unsigned PANEL_WIDTH_DEF  = 128;
	localparam int unsigned PANEL_HEIGHT_DEF = 160;
	localparam int unsigned CMD_DEPTH_DEF    = 2;

	// Pixel counter covers a 256 x 256 panel
	localparam int unsigned COUNT_W = 17;

	// Operation codes on the draw channel
	localparam logic [2:0] OP_TICK        = 3'd0;
	localparam logic [2:0] OP_FILL_SCREEN = 3'd1;
	localparam logic [2:0] OP_RECT        = 3'd2;
	localparam logic [2:0] OP_IMAGE_START = 3'd3;
	localparam logic [2:0] OP_IMAGE_PIXEL = 3'd4;
	localparam logic [2:0] OP_GLYPH       = 3'd5;

	// Command kinds after classification
	localparam logic [2:0] K_TICK  = 3'd0;
	localparam logic [2:0] K_FILL  = 3'd1;
	localparam logic [2:0] K_IMAGE = 3'd2;
	localparam logic [2:0] K_PIXEL = 3'd3;
	localparam logic [2:0] K_GLYPH = 3'd4;

	// Panel controller commands
	localparam logic [7:0] CMD_CASET = 8'h2A;
	localparam logic [7:0] CMD_RASET = 8'h2B;
	localparam logic [7:0] CMD_RAMWR = 8'h2C;

	typedef struct packed {
		logic [2:0]         kind;
		logic [7:0]         xs;
		logic [7:0]         xe;
		logic [7:0]         ys;
		logic [7:0]         ye;
		logic [COUNT_W-1:0] count;
		logic [15:0]        color;
		logic [34:0]        glyph;
	} cmd_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       is_data;
		logic       end_of_draw;
	} txb_t;

endpackage

`default_nettype wire

/* src/tdcs_if.sv */
// Stream interfaces for the draw request and transmit byte channels.
`timescale 1ns / 1ps
`default_nettype none

interface tdcs_draw_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [6:0]  x_start;
	logic [6:0]  x_end;
	logic [7:0]  y_start;
	logic [7:0]  y_end;
	logic [15:0] color;
	logic [34:0] glyph_bits;

	modport source (
		output valid, operation, x_start, x_end, y_start, y_end, color, glyph_bits,
		input  ready
	);
	modport sink (
		input  valid, operation, x_start, x_end, y_start, y_end, color, glyph_bits,
		output ready
	);
endinterface

interface tdcs_tx_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       is_data;
	logic       end_of_draw;

	modport source (output valid, tx_byte, is_data, end_of_draw, input ready);
	modport sink (input valid, tx_byte, is_data, end_of_draw, output ready);
endinterface

`default_nettype wire

/* src/tdcs_fifo.sv */
// Small register FIFO with valid/ready on both sides.
`timescale 1ns / 1ps
`default_nettype none

module tdcs_fifo #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output      logic             in_ready,
	input  wire logic [Width-1:0] in_data,
	output      logic             out_valid,
	input  wire logic             out_ready,
	output      logic [Width-1:0] out_data
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [PtrW-1:0]  wr_q, rd_q;
	logic [CntW-1:0]  cnt_q;
	logic             push, pop;

	assign in_ready  = (cnt_q != CntW'(Depth));
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CntW'(push) - CntW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_data;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(Depth))
		else $error("fifo count past depth");

endmodule

`default_nettype wire

/* src/tdcs_front.sv */
// Front end: accepts draw items, classifies them and computes window and pixel count.
`timescale 1ns / 1ps
`default_nettype none

module tdcs_front #(
	parameter int unsigned PANEL_WIDTH  = tdcs_pkg::PANEL_WIDTH_DEF,
	parameter int unsigned PANEL_HEIGHT = tdcs_pkg::PANEL_HEIGHT_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	tdcs_draw_if.sink      draw,
	output logic           cmd_valid,
	input  wire logic      cmd_ready,
	output tdcs_pkg::cmd_t cmd
);

	localparam int unsigned CW      = tdcs_pkg::COUNT_W;
	localparam int unsigned FullPix = PANEL_WIDTH * PANEL_HEIGHT;
	localparam logic [CW-1:0] FullCount = CW'(FullPix);
	localparam logic [7:0] LastCol = 8'(PANEL_WIDTH - 1);
	localparam logic [7:0] LastRow = 8'(PANEL_HEIGHT - 1);

	tdcs_pkg::cmd_t cmd_d, cmd_s1;
	logic           v_s1;
	logic           keep;
	logic           adv;
	logic [7:0]     rect_w;
	logic [8:0]     rect_h;
	logic [CW-1:0]  rect_area;
	logic           rect_ok;

	assign adv        = !v_s1 || cmd_ready;
	assign draw.ready = adv;
	assign cmd_valid  = v_s1;
	assign cmd        = cmd_s1;

	assign rect_ok   = (draw.x_end >= draw.x_start) && (draw.y_end >= draw.y_start);
	assign rect_w    = 8'({1'b0, draw.x_end} - {1'b0, draw.x_start}) + 8'd1;
	assign rect_h    = 9'({1'b0, draw.y_end} - {1'b0, draw.y_start}) + 9'd1;
	assign rect_area = CW'(rect_w) * CW'(rect_h);

	always_comb begin
		cmd_d = '0;
		keep  = 1'b1;
		unique case (draw.operation)
			tdcs_pkg::OP_TICK: begin
				cmd_d.kind = tdcs_pkg::K_TICK;
			end
			tdcs_pkg::OP_FILL_SCREEN: begin
				cmd_d.kind  = tdcs_pkg::K_FILL;
				cmd_d.xe    = LastCol;
				cmd_d.ye    = LastRow;
				cmd_d.count = FullCount;
				cmd_d.color = draw.color;
			end
			tdcs_pkg::OP_RECT: begin
				cmd_d.kind  = tdcs_pkg::K_FILL;
				cmd_d.xs    = {1'b0, draw.x_start};
				cmd_d.xe    = {1'b0, draw.x_end};
				cmd_d.ys    = draw.y_start;
				cmd_d.ye    = draw.y_end;
				cmd_d.count = rect_ok ? rect_area : '0;
				cmd_d.color = draw.color;
			end
			tdcs_pkg::OP_IMAGE_START: begin
				cmd_d.kind  = tdcs_pkg::K_IMAGE;
				cmd_d.xe    = LastCol;
				cmd_d.ye    = LastRow;
				cmd_d.count = FullCount;
			end
			tdcs_pkg::OP_IMAGE_PIXEL: begin
				cmd_d.kind  = tdcs_pkg::K_PIXEL;
				cmd_d.color = draw.color;
			end
			tdcs_pkg::OP_GLYPH: begin
				cmd_d.kind  = tdcs_pkg::K_GLYPH;
				cmd_d.xs    = {1'b0, draw.x_start};
				cmd_d.xe    = {1'b0, draw.x_start};
				cmd_d.ys    = draw.y_start;
				cmd_d.ye    = draw.y_start;
				cmd_d.color = draw.color;
				cmd_d.glyph = draw.glyph_bits;
			end
			default: begin
				// unused opcodes are swallowed here
				keep = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= draw.valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

`default_nettype wire

/* src/tdcs_engine.sv */
// Back end: draw sequencer producing window, RAM write and color bytes into a byte queue.
`timescale 1ns / 1ps
`default_nettype none

module tdcs_engine (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_ready,
	input  wire tdcs_pkg::cmd_t cmd,
	tdcs_tx_if.source           tx
);

	localparam int unsigned CW = tdcs_pkg::COUNT_W;

	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_FILL  = 2'd1;
	localparam logic [1:0] MODE_IMAGE = 2'd2;
	localparam logic [1:0] MODE_GLYPH = 2'd3;

	// header byte positions
	localparam logic [3:0] HDR_CASET = 4'd0;
	localparam logic [3:0] HDR_XS    = 4'd2;
	localparam logic [3:0] HDR_XE    = 4'd4;
	localparam logic [3:0] HDR_RASET = 4'd5;
	localparam logic [3:0] HDR_YS    = 4'd7;
	localparam logic [3:0] HDR_YE    = 4'd9;
	localparam logic [3:0] HDR_RAMWR = 4'd10;
	localparam logic [3:0] HDR_LEN   = 4'd11;

	localparam logic [2:0] GLYPH_LAST_COL = 3'd4;
	localparam logic [2:0] GLYPH_LAST_ROW = 3'd6;

	localparam int unsigned QDepth = 4;

	logic [1:0]    mode_q, mode_d;
	logic [3:0]    hdr_q, hdr_d;
	logic [CW-1:0] left_q, left_d, left_dec;
	logic          lowb_q, lowb_d;
	logic [7:0]    xs_q, xe_q, ys_q, ye_q;
	logic [7:0]    xs_d, xe_d, ys_d, ye_d;
	logic [15:0]   color_q, color_d;
	logic [34:0]   glyph_q, glyph_d;
	logic [2:0]    gcol_q, gcol_d, grow_q, grow_d;

	logic          fire;
	logic [1:0]    n_emit;
	tdcs_pkg::txb_t e0, e1;

	logic [7:0]    hx, hxe, hy, hye, hbyte;
	logic [5:0]    gbit;
	logic [15:0]   pcolor;

	// byte queue
	tdcs_pkg::txb_t q_q [QDepth];
	logic [1:0]    wr_q, rd_q;
	logic [2:0]    cnt_q;
	logic          pop;

	assign cmd_ready = (cnt_q <= 3'd2);
	assign fire      = cmd_valid && cmd_ready;

	assign tx.valid       = (cnt_q != 3'd0);
	assign tx.tx_byte     = q_q[rd_q].tx_byte;
	assign tx.is_data     = q_q[rd_q].is_data;
	assign tx.end_of_draw = q_q[rd_q].end_of_draw;
	assign pop            = tx.valid && tx.ready;

	// glyph pixel gets a one-pixel window offset from its origin
	assign hx  = (mode_q == MODE_GLYPH) ? xs_q + 8'(gcol_q) : xs_q;
	assign hy  = (mode_q == MODE_GLYPH) ? ys_q + 8'(grow_q) : ys_q;
	assign hxe = (mode_q == MODE_GLYPH) ? hx : xe_q;
	assign hye = (mode_q == MODE_GLYPH) ? hy : ye_q;

	assign gbit   = 6'(gcol_q) * 6'd7 + 6'(grow_q);
	assign pcolor = (mode_q == MODE_GLYPH && !glyph_q[gbit]) ? 16'h0000 : color_q;

	assign left_dec = (left_q != '0) ? left_q - 1'b1 : left_q;

	always_comb begin
		unique case (hdr_q)
			HDR_CASET: hbyte = tdcs_pkg::CMD_CASET;
			HDR_XS:    hbyte = hx;
			HDR_XE:    hbyte = hxe;
			HDR_RASET: hbyte = tdcs_pkg::CMD_RASET;
			HDR_YS:    hbyte = hy;
			HDR_YE:    hbyte = hye;
			HDR_RAMWR: hbyte = tdcs_pkg::CMD_RAMWR;
			default:   hbyte = 8'h00;
		endcase
	end

	always_comb begin
		mode_d  = mode_q;
		hdr_d   = hdr_q;
		left_d  = left_q;
		lowb_d  = lowb_q;
		xs_d    = xs_q;
		xe_d    = xe_q;
		ys_d    = ys_q;
		ye_d    = ye_q;
		color_d = color_q;
		glyph_d = glyph_q;
		gcol_d  = gcol_q;
		grow_d  = grow_q;
		n_emit  = 2'd0;
		e0      = '0;
		e1      = '0;
		if (fire) begin
			unique case (cmd.kind)
				tdcs_pkg::K_FILL, tdcs_pkg::K_IMAGE, tdcs_pkg::K_GLYPH: begin
					// a start while busy is dropped
					if (mode_q == MODE_IDLE) begin
						mode_d  = (cmd.kind == tdcs_pkg::K_FILL)  ? MODE_FILL :
						          (cmd.kind == tdcs_pkg::K_IMAGE) ? MODE_IMAGE : MODE_GLYPH;
						hdr_d   = HDR_CASET;
						left_d  = cmd.count;
						lowb_d  = 1'b0;
						xs_d    = cmd.xs;
						xe_d    = cmd.xe;
						ys_d    = cmd.ys;
						ye_d    = cmd.ye;
						color_d = cmd.color;
						gcol_d  = 3'd0;
						grow_d  = 3'd0;
						if (cmd.kind == tdcs_pkg::K_GLYPH) begin
							glyph_d = cmd.glyph;
						end
					end
				end
				tdcs_pkg::K_PIXEL: begin
					if (mode_q == MODE_IMAGE && hdr_q == HDR_LEN) begin
						left_d         = left_dec;
						n_emit         = 2'd2;
						e0.tx_byte     = cmd.color[15:8];
						e0.is_data     = 1'b1;
						e1.tx_byte     = cmd.color[7:0];
						e1.is_data     = 1'b1;
						e1.end_of_draw = (left_dec == '0);
						if (left_dec == '0) begin
							mode_d = MODE_IDLE;
						end
					end
				end
				tdcs_pkg::K_TICK: begin
					if (mode_q != MODE_IDLE && hdr_q != HDR_LEN) begin
						n_emit     = 2'd1;
						e0.tx_byte = hbyte;
						e0.is_data = !(hdr_q == HDR_CASET || hdr_q == HDR_RASET ||
						               hdr_q == HDR_RAMWR);
						hdr_d      = hdr_q + 4'd1;
						// empty rectangle ends on the RAM write command
						if (hdr_q == HDR_RAMWR && mode_q == MODE_FILL && left_q == '0) begin
							e0.end_of_draw = 1'b1;
							mode_d         = MODE_IDLE;
						end
					end else if (mode_q == MODE_FILL || mode_q == MODE_GLYPH) begin
						n_emit     = 2'd1;
						e0.is_data = 1'b1;
						if (!lowb_q) begin
							e0.tx_byte = pcolor[15:8];
							lowb_d     = 1'b1;
						end else begin
							e0.tx_byte = pcolor[7:0];
							lowb_d     = 1'b0;
							if (mode_q == MODE_FILL) begin
								left_d = left_dec;
								if (left_dec == '0) begin
									e0.end_of_draw = 1'b1;
									mode_d         = MODE_IDLE;
								end
							end else if (gcol_q == GLYPH_LAST_COL && grow_q == GLYPH_LAST_ROW) begin
								e0.end_of_draw = 1'b1;
								mode_d         = MODE_IDLE;
							end else begin
								// next glyph pixel: column by column, top row first
								hdr_d = HDR_CASET;
								if (grow_q == GLYPH_LAST_ROW) begin
									grow_d = 3'd0;
									gcol_d = gcol_q + 3'd1;
								end else begin
									grow_d = grow_q + 3'd1;
								end
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			hdr_q   <= HDR_CASET;
			left_q  <= '0;
			lowb_q  <= 1'b0;
			xs_q    <= '0;
			xe_q    <= '0;
			ys_q    <= '0;
			ye_q    <= '0;
			color_q <= '0;
			glyph_q <= '0;
			gcol_q  <= '0;
			grow_q  <= '0;
			wr_q    <= '0;
			rd_q    <= '0;
			cnt_q   <= '0;
		end else begin
			mode_q  <= mode_d;
			hdr_q   <= hdr_d;
			left_q  <= left_d;
			lowb_q  <= lowb_d;
			xs_q    <= xs_d;
			xe_q    <= xe_d;
			ys_q    <= ys_d;
			ye_q    <= ye_d;
			color_q <= color_d;
			glyph_q <= glyph_d;
			gcol_q  <= gcol_d;
			grow_q  <= grow_d;
			wr_q    <= wr_q + n_emit;
			rd_q    <= rd_q + 2'(pop);
			cnt_q   <= cnt_q + 3'(n_emit) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (n_emit != 2'd0) begin
			q_q[wr_q] <= e0;
		end
		if (n_emit == 2'd2) begin
			q_q[wr_q + 2'd1] <= e1;
		end
	end

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(QDepth))
		else $error("byte queue overflow");

	a_hdr_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_q <= HDR_LEN)
		else $error("header index out of range");

	a_glyph_pos: assert property (@(posedge clk) disable iff (!arst_n)
		grow_q <= GLYPH_LAST_ROW && gcol_q <= GLYPH_LAST_COL)
		else $error("glyph position out of range");

	a_eod_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && tx.end_of_draw && !tx.is_data |-> tx.tx_byte == tdcs_pkg::CMD_RAMWR)
		else $error("end of draw on a command other than RAM write");

endmodule

`default_nettype wire

/* src/tft_draw_command_stream_core.sv */
// Top level of the TFT draw command stream generator.
//
//  channel | dir | handshake    | payload
//  draw    | in  | valid/ready  | operation, x_start, x_end, y_start, y_end, color, glyph_bits
//  tx      | out | valid/ready  | tx_byte, is_data, end_of_draw
//
// One draw item is taken per cycle while draw.ready is high; a tick's header or color byte
// passes the front register, the command queue and the byte queue before it reaches tx.
// Image pixel items make two bytes each for the single-byte tx port.
// The classified command queue lets draw keep flowing while tx stalls.
// arst_n clears all control state; the block comes up idle.
`timescale 1ns / 1ps
`default_nettype none

module tft_draw_command_stream_core #(
	parameter int unsigned PANEL_WIDTH  = tdcs_pkg::PANEL_WIDTH_DEF,
	parameter int unsigned PANEL_HEIGHT = tdcs_pkg::PANEL_HEIGHT_DEF,
	parameter int unsigned CMD_DEPTH    = tdcs_pkg::CMD_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tdcs_draw_if.sink draw,
	tdcs_tx_if.source tx
);

	localparam int unsigned CmdW = $bits(tdcs_pkg::cmd_t);

	logic           f_valid, f_ready;
	tdcs_pkg::cmd_t f_cmd;
	logic           b_valid, b_ready;
	logic [CmdW-1:0] b_bits;
	tdcs_pkg::cmd_t b_cmd;

	assign b_cmd = tdcs_pkg::cmd_t'(b_bits);

	tdcs_front #(
		.PANEL_WIDTH (PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.draw     (draw),
		.cmd_valid(f_valid),
		.cmd_ready(f_ready),
		.cmd      (f_cmd)
	);

	tdcs_fifo #(
		.Width(CmdW),
		.Depth(CMD_DEPTH)
	) u_cmd_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (f_valid),
		.in_ready (f_ready),
		.in_data  (CmdW'(f_cmd)),
		.out_valid(b_valid),
		.out_ready(b_ready),
		.out_data (b_bits)
	);

	tdcs_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(b_valid),
		.cmd_ready(b_ready),
		.cmd      (b_cmd),
		.tx       (tx)
	);

endmodule

`default_nettype wire
